[design/hkm_pkg.sv]
`timescale 1ns / 1ps
package hkm_pkg;

	localparam int NUM_SLOTS   = 6;
	localparam int KEY_W       = 8;
	localparam int OP_W        = 3;
	localparam int MOD_W       = 2;
	localparam int BIDX_W      = 2;
	localparam int POS_W       = 16;
	localparam int BTN_W       = 3;
	localparam int DELTA_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MAG_W       = 16;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// ceil(2^19 / 3): |d| * 2 / 3 == (|d| * RECIP3) >> 18 for |d| < 2^17
	localparam logic [RECIP_W-1:0] RECIP3 = 18'd174763;

	localparam logic REPORT_MOUSE    = 1'b0;
	localparam logic REPORT_KEYBOARD = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_KEY_PRESS   = 3'd0,
		OP_KEY_RELEASE = 3'd1,
		OP_BTN_PRESS   = 3'd2,
		OP_BTN_RELEASE = 3'd3,
		OP_MOVE        = 3'd4,
		OP_CAPTURE_ON  = 3'd5,
		OP_CAPTURE_OFF = 3'd6
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1
	} cfg_idx_t;

	typedef logic [NUM_SLOTS-1:0][KEY_W-1:0] slots_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} axis_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  code;
		logic [MOD_W-1:0]  mods;
		logic [BIDX_W-1:0] bidx;
		axis_t             ax;
		axis_t             ay;
	} cmd_t;

	typedef struct packed {
		logic [BTN_W-1:0]   buttons;
		logic [DELTA_W-1:0] dx;
		logic [DELTA_W-1:0] dy;
	} mouse_img_t;

	typedef struct packed {
		logic [MOD_W-1:0] mods;
		slots_t           slots;
	} kbd_img_t;

	typedef struct packed {
		logic                      kind;
		logic [MOD_W-1:0]          modifiers;
		slots_t                    slots;
		logic [BTN_W-1:0]          buttons;
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic                      last;
	} rpt_t;

	function automatic logic [DELTA_W-1:0] scale_delta(input axis_t a);
		logic [MAG_W+RECIP_W-1:0] prod;
		logic [DELTA_W-1:0]       q;
		prod = a.mag * RECIP3;
		q = prod[RECIP_SHIFT +: DELTA_W];
		return a.neg ? (~q + 1'b1) : q;
	endfunction

endpackage

[design/hkm_evt_if.sv]
`timescale 1ns / 1ps
interface hkm_evt_if;
	import hkm_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [KEY_W-1:0]  key_code;
	logic [MOD_W-1:0]  modifier_mask;
	logic [BIDX_W-1:0] button_index;
	logic [POS_W-1:0]  pointer_x;
	logic [POS_W-1:0]  pointer_y;

	modport source (
		output valid, opcode, key_code, modifier_mask, button_index, pointer_x, pointer_y,
		input  ready
	);
	modport sink (
		input  valid, opcode, key_code, modifier_mask, button_index, pointer_x, pointer_y,
		output ready
	);
endinterface

[design/hkm_rpt_if.sv]
`timescale 1ns / 1ps
interface hkm_rpt_if;
	import hkm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      report_kind;
	logic [MOD_W-1:0]          modifiers;
	logic [KEY_W-1:0]          key_slot_0;
	logic [KEY_W-1:0]          key_slot_1;
	logic [KEY_W-1:0]          key_slot_2;
	logic [KEY_W-1:0]          key_slot_3;
	logic [KEY_W-1:0]          key_slot_4;
	logic [KEY_W-1:0]          key_slot_5;
	logic [BTN_W-1:0]          buttons;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic                      last;

	modport source (
		output valid, report_kind, modifiers, key_slot_0, key_slot_1, key_slot_2,
			key_slot_3, key_slot_4, key_slot_5, buttons, delta_x, delta_y, last,
		input  ready
	);
	modport sink (
		input  valid, report_kind, modifiers, key_slot_0, key_slot_1, key_slot_2,
			key_slot_3, key_slot_4, key_slot_5, buttons, delta_x, delta_y, last,
		output ready
	);
endinterface

[design/hkm_cfg_if.sv]
`timescale 1ns / 1ps
interface hkm_cfg_if;
	import hkm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/hid_keyboard_mouse_report_builder.sv]
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// evt      in   valid / ready  opcode, key_code, modifier_mask, button_index, pointer_x/y
// cfg      in   valid / ready  index (0 center_x, 1 center_y), data
// rpt      out  valid / ready  report_kind, modifiers, key_slot_0..5, buttons, delta_x/y, last
//
// an event that gives a mouse and a keyboard report sends the mouse report first and holds the
// back end while the keyboard report waits in a pending register for the single output register
// the front end and a two-entry command queue keep taking events while a report waits, until the queue is full
// an event's first report is registered when the back end takes the event; cfg is always ready
// reset clears the key, button, delta, capture and last-sent images and both centers
module hid_keyboard_mouse_report_builder (
	input  logic      clk,
	input  logic      arst_n,
	hkm_evt_if.sink   evt,
	hkm_cfg_if.sink   cfg,
	hkm_rpt_if.source rpt
);
	import hkm_pkg::*;

	logic  push_valid;
	logic  push_ready;
	cmd_t  push_cmd;
	logic  pop_valid;
	logic  pop_ready;
	cmd_t  pop_cmd;
	rpt_t  out_rpt;

	hkm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	hkm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	hkm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.out_valid (rpt.valid),
		.out_ready (rpt.ready),
		.out_rpt   (out_rpt)
	);

	assign rpt.report_kind = out_rpt.kind;
	assign rpt.modifiers   = out_rpt.modifiers;
	assign rpt.key_slot_0  = out_rpt.slots[0];
	assign rpt.key_slot_1  = out_rpt.slots[1];
	assign rpt.key_slot_2  = out_rpt.slots[2];
	assign rpt.key_slot_3  = out_rpt.slots[3];
	assign rpt.key_slot_4  = out_rpt.slots[4];
	assign rpt.key_slot_5  = out_rpt.slots[5];
	assign rpt.buttons     = out_rpt.buttons;
	assign rpt.delta_x     = out_rpt.delta_x;
	assign rpt.delta_y     = out_rpt.delta_y;
	assign rpt.last        = out_rpt.last;
endmodule

[design/hkm_front.sv]
`timescale 1ns / 1ps
module hkm_front (
	input  logic           clk,
	input  logic           arst_n,
	hkm_evt_if.sink        evt,
	hkm_cfg_if.sink        cfg,
	output logic           push_valid,
	input  logic           push_ready,
	output hkm_pkg::cmd_t  push_cmd
);
	import hkm_pkg::*;

	logic [POS_W-1:0] center_x_q;
	logic [POS_W-1:0] center_y_q;
	logic [POS_W:0]   diff_x;
	logic [POS_W:0]   diff_y;
	logic [POS_W:0]   neg_x;
	logic [POS_W:0]   neg_y;
	logic             known_op;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_CENTER_X: center_x_q <= cfg.data;
				CFG_CENTER_Y: center_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// signed offset from the capture center, kept as sign and magnitude
	assign diff_x = {1'b0, evt.pointer_x} - {1'b0, center_x_q};
	assign diff_y = {1'b0, evt.pointer_y} - {1'b0, center_y_q};
	assign neg_x  = ~diff_x + 1'b1;
	assign neg_y  = ~diff_y + 1'b1;

	always_comb begin
		case (op_t'(evt.opcode))
			OP_KEY_PRESS, OP_KEY_RELEASE, OP_BTN_PRESS, OP_BTN_RELEASE,
			OP_MOVE, OP_CAPTURE_ON, OP_CAPTURE_OFF: known_op = 1'b1;
			default: known_op = 1'b0;
		endcase
	end

	// unknown opcodes are taken and dropped here
	assign evt.ready  = push_ready;
	assign push_valid = evt.valid && known_op;

	always_comb begin
		push_cmd.op     = op_t'(evt.opcode);
		push_cmd.code   = evt.key_code;
		push_cmd.mods   = evt.modifier_mask;
		push_cmd.bidx   = evt.button_index;
		push_cmd.ax.neg = diff_x[POS_W];
		push_cmd.ax.mag = diff_x[POS_W] ? neg_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
		push_cmd.ay.neg = diff_y[POS_W];
		push_cmd.ay.mag = diff_y[POS_W] ? neg_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
	end
endmodule

[design/hkm_queue.sv]
`timescale 1ns / 1ps
module hkm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  hkm_pkg::cmd_t  push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output hkm_pkg::cmd_t  pop_cmd
);
	import hkm_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

[design/hkm_back.sv]
`timescale 1ns / 1ps
module hkm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  hkm_pkg::cmd_t  cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output hkm_pkg::rpt_t  out_rpt
);
	import hkm_pkg::*;

	logic               capture_q;
	logic [MOD_W-1:0]   mods_q;
	slots_t             slots_q;
	logic [BTN_W-1:0]   buttons_q;
	logic [DELTA_W-1:0] dx_q;
	logic [DELTA_W-1:0] dy_q;
	mouse_img_t         sent_mouse_q;
	kbd_img_t           sent_kbd_q;

	rpt_t               out_q;
	logic               out_valid_q;
	rpt_t               pend_q;
	logic               pend_valid_q;

	logic               n_capture;
	logic [MOD_W-1:0]   n_mods;
	slots_t             n_slots;
	logic [BTN_W-1:0]   n_buttons;
	logic [DELTA_W-1:0] n_dx;
	logic [DELTA_W-1:0] n_dy;
	slots_t             press_slots;
	slots_t             rel_slots;
	slots_t             shifted;
	logic [BTN_W-1:0]   btn_mask;
	mouse_img_t         n_mouse;
	kbd_img_t           n_kbd;
	logic               m_diff;
	logic               k_diff;
	rpt_t               mouse_rpt;
	rpt_t               kbd_rpt;
	logic               out_free;
	logic               take;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_ready = out_free && !pend_valid_q;
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_rpt   = out_q;

	// press: first slot holding the code or empty gets the code
	always_comb begin
		logic found;
		found       = 1'b0;
		press_slots = slots_q;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!found && (slots_q[k] == cmd.code || slots_q[k] == '0)) begin
				press_slots[k] = cmd.code;
				found          = 1'b1;
			end
		end
	end

	// release: from the matching slot on, later slots move down one
	assign shifted = slots_t'(slots_q >> KEY_W);

	always_comb begin
		logic seen;
		seen      = 1'b0;
		rel_slots = slots_q;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			seen = seen | (slots_q[k] == cmd.code);
			if (seen) begin
				rel_slots[k] = shifted[k];
			end
		end
	end

	assign btn_mask = BTN_W'(1) << cmd.bidx;

	always_comb begin
		n_capture = capture_q;
		n_mods    = mods_q;
		n_slots   = slots_q;
		n_buttons = buttons_q;
		n_dx      = dx_q;
		n_dy      = dy_q;
		case (cmd.op)
			OP_KEY_PRESS: begin
				if (cmd.mods != '0) begin
					n_mods = mods_q | cmd.mods;
				end else begin
					n_slots = press_slots;
				end
			end
			OP_KEY_RELEASE: begin
				if (cmd.mods != '0) begin
					n_mods = mods_q & ~cmd.mods;
				end else begin
					n_slots = rel_slots;
				end
			end
			OP_BTN_PRESS:   n_buttons = buttons_q | btn_mask;
			OP_BTN_RELEASE: n_buttons = buttons_q & ~btn_mask;
			OP_MOVE: begin
				if (capture_q) begin
					n_dx = scale_delta(cmd.ax);
					n_dy = scale_delta(cmd.ay);
				end
			end
			OP_CAPTURE_ON:  n_capture = 1'b1;
			OP_CAPTURE_OFF: n_capture = 1'b0;
			default: ;
		endcase
	end

	assign n_mouse = '{buttons: n_buttons, dx: n_dx, dy: n_dy};
	assign n_kbd   = '{mods: n_mods, slots: n_slots};
	assign m_diff  = n_capture && (n_mouse != sent_mouse_q);
	assign k_diff  = n_capture && (n_kbd != sent_kbd_q);

	always_comb begin
		mouse_rpt         = '0;
		mouse_rpt.kind    = REPORT_MOUSE;
		mouse_rpt.buttons = n_buttons;
		mouse_rpt.delta_x = n_dx;
		mouse_rpt.delta_y = n_dy;
		mouse_rpt.last    = !k_diff;

		kbd_rpt           = '0;
		kbd_rpt.kind      = REPORT_KEYBOARD;
		kbd_rpt.modifiers = n_mods;
		kbd_rpt.slots     = n_slots;
		kbd_rpt.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q    <= 1'b0;
			mods_q       <= '0;
			slots_q      <= '0;
			buttons_q    <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			sent_mouse_q <= '0;
			sent_kbd_q   <= '0;
		end else if (take) begin
			capture_q <= n_capture;
			mods_q    <= n_mods;
			slots_q   <= n_slots;
			buttons_q <= n_buttons;
			dx_q      <= n_dx;
			dy_q      <= n_dy;
			if (n_capture) begin
				sent_mouse_q <= n_mouse;
				sent_kbd_q   <= n_kbd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (take && (m_diff || k_diff)) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= m_diff && k_diff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end else if (take && (m_diff || k_diff)) begin
			out_q <= m_diff ? mouse_rpt : kbd_rpt;
		end
		if (take) begin
			pend_q <= kbd_rpt;
		end
	end
endmodule
